>>> hdl/u8d_pkg.sv
package u8d_pkg;

  localparam int unsigned CpW       = 21;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;
  localparam int unsigned QCntW     = 3;

  localparam logic [CpW-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMaxScalar   = 21'h10FFFF;
  localparam logic [CpW-1:0] CpSurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] CpSurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMin2        = 21'h000080;
  localparam logic [CpW-1:0] CpMin3        = 21'h000800;
  localparam logic [CpW-1:0] CpMin4        = 21'h010000;

  localparam logic [7:0] MaskLead2 = 8'hE0;
  localparam logic [7:0] CodeLead2 = 8'hC0;
  localparam logic [7:0] MaskLead3 = 8'hF0;
  localparam logic [7:0] CodeLead3 = 8'hE0;
  localparam logic [7:0] MaskLead4 = 8'hF8;
  localparam logic [7:0] CodeLead4 = 8'hF0;
  localparam logic [7:0] MaskCont  = 8'hC0;
  localparam logic [7:0] CodeCont  = 8'h80;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic           last_of_run;
  } result_t;

  // Words handed from the front end to the queue at once.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic           done;
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic [1:0]     need;
    logic [CpW-1:0] value;
  } lead_t;

  // Decode a byte seen while no sequence is open.
  function automatic lead_t lead_decode(input logic [7:0] b, input logic [1:0] following);
    lead_t res;
    res.done       = 1'b1;
    res.code_point = CpReplacement;
    res.malformed  = 1'b1;
    res.need       = 2'd0;
    res.value      = '0;
    if (b[7] == 1'b0) begin
      res.code_point = {13'd0, b};
      res.malformed  = 1'b0;
    end else if ((b & MaskLead2) == CodeLead2) begin
      res.need  = 2'd1;
      res.value = {16'd0, b[4:0]};
      if (b[4:1] != 4'd0) begin
        res.done = (following < res.need);
      end
    end else if ((b & MaskLead3) == CodeLead3) begin
      res.need  = 2'd2;
      res.value = {17'd0, b[3:0]};
      res.done  = (following < res.need);
    end else if ((b & MaskLead4) == CodeLead4) begin
      res.need  = 2'd3;
      res.value = {18'd0, b[2:0]};
      res.done  = (following < res.need);
    end
    return res;
  endfunction

endpackage

>>> hdl/utf8_codepoint_decoder.sv
// UTF-8 to Unicode scalar decoder. Each input word is one string byte plus the
// count of bytes still to come (saturated at three). ASCII and each completed
// multi-byte sequence give one scalar; malformed input gives U+FFFD with
// malformed set. A byte that breaks an open sequence gives U+FFFD for the
// broken sequence and is then decoded afresh as a lead byte, so it may give a
// second word; last_of_run marks the final word caused by a byte. Sequences
// cut short by the string end are rejected at the lead byte.
// Rate: one byte accepted per cycle while the queue has room, and one result
// word delivered per cycle while out_ready_i is high. The front end decodes a
// byte combinationally and pushes zero, one or two words into a four-word
// queue; the queue drains one word a cycle while out_ready_i is high. The
// input is ready while the queue has room for two words.
module utf8_codepoint_decoder import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [1:0]  bytes_following_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        malformed_o,
  output logic        last_of_run_o
);

  push_t   push;
  logic    room;
  result_t head;

  // Front end: hold the partial code point and classify each byte.
  u8d_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .room_i            (room),
    .data_byte_i       (data_byte_i),
    .bytes_following_i (bytes_following_i),
    .in_ready_o        (in_ready_o),
    .push_o            (push)
  );

  // Back end: queue result words and hand them out one at a time.
  u8d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign code_point_o  = head.code_point;
  assign malformed_o   = head.malformed;
  assign last_of_run_o = head.last_of_run;

endmodule

>>> hdl/u8d_front.sv
module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       room_i,
  input  logic [7:0] data_byte_i,
  input  logic [1:0] bytes_following_i,
  output logic       in_ready_o,
  output push_t      push_o
);

  logic [1:0]     pend_q, pend_d;
  logic [1:0]     seqlen_q, seqlen_d;
  logic [CpW-1:0] part_q, part_d;
  logic           take;
  lead_t          ld;
  logic [CpW-1:0] nv;
  logic [1:0]     pend_dec;
  logic           bad_val;

  assign in_ready_o = room_i;
  assign take       = in_valid_i & room_i;
  assign ld         = lead_decode(data_byte_i, bytes_following_i);
  assign nv         = {part_q[CpW-7:0], data_byte_i[5:0]};
  assign pend_dec   = pend_q - 2'd1;

  always_comb begin
    bad_val = (nv > CpMaxScalar) || ((nv >= CpSurrLo) && (nv <= CpSurrHi)) ||
              (nv < CpMin2) ||
              ((nv < CpMin3) && (seqlen_q > 2'd1)) ||
              ((nv < CpMin4) && (seqlen_q > 2'd2));
  end

  always_comb begin
    pend_d   = pend_q;
    seqlen_d = seqlen_q;
    part_d   = part_q;
    push_o   = '0;
    if (take) begin
      if (pend_q == 2'd0) begin
        if (ld.done) begin
          push_o.count = 2'd1;
          push_o.r0    = '{code_point: ld.code_point, malformed: ld.malformed,
                           last_of_run: 1'b1};
        end else begin
          pend_d   = ld.need;
          seqlen_d = ld.need;
          part_d   = ld.value;
        end
      end else if ((data_byte_i & MaskCont) != CodeCont) begin
        // Close the broken sequence, then retry the byte as a lead.
        push_o.r0 = '{code_point: CpReplacement, malformed: 1'b1, last_of_run: 1'b1};
        if (ld.done) begin
          push_o.count          = 2'd2;
          push_o.r0.last_of_run = 1'b0;
          push_o.r1 = '{code_point: ld.code_point, malformed: ld.malformed,
                        last_of_run: 1'b1};
          pend_d   = 2'd0;
          seqlen_d = 2'd0;
          part_d   = '0;
        end else begin
          push_o.count = 2'd1;
          pend_d   = ld.need;
          seqlen_d = ld.need;
          part_d   = ld.value;
        end
      end else if (pend_dec != 2'd0) begin
        pend_d = pend_dec;
        part_d = nv;
      end else begin
        push_o.count = 2'd1;
        push_o.r0 = '{code_point: bad_val ? CpReplacement : nv, malformed: bad_val,
                      last_of_run: 1'b1};
        pend_d   = 2'd0;
        seqlen_d = 2'd0;
        part_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 2'd0;
      seqlen_q <= 2'd0;
      part_q   <= '0;
    end else begin
      pend_q   <= pend_d;
      seqlen_q <= seqlen_d;
      part_q   <= part_d;
    end
  end

endmodule

>>> hdl/u8d_queue.sv
module u8d_queue import u8d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t head_o
);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign head_o      = mem_q[rd_q];
  // Need space for two words from a single byte.
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + QPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.count);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_q + QCntW'(push_i.count) - QCntW'(pop);
    end
  end

endmodule
